// ===== design/tbcm_pkg.sv =====
// Shared types, widths, register indexes and reset values for the
// temperature band cooling monitor. No dependencies.
package tbcm_pkg;

   localparam int SAMPLE_W = 12;
   localparam int TOL_W = 11;
   localparam int AMT_W = 8;
   localparam int ACT_W = 2;
   localparam int LVL_W = SAMPLE_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 12;
   localparam int DEFAULT_RING_DEPTH = 8;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE = 2'd0,
      ACT_SHUTDOWN = 2'd1,
      ACT_INCREASE = 2'd2,
      ACT_DECREASE = 2'd3
   } act_type;

   localparam logic [CSR_IDX_W-1:0] REG_CRIT_HIGH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_LOW = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REC_HIGH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REC_LOW = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_ADJ = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_ADJ = 3'd7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] crit_high;
      logic signed [SAMPLE_W-1:0] crit_low;
      logic signed [SAMPLE_W-1:0] rec_high;
      logic signed [SAMPLE_W-1:0] rec_low;
      logic signed [SAMPLE_W-1:0] ideal;
      logic [TOL_W-1:0] tolerance;
      logic [AMT_W-1:0] full_adjust;
      logic [AMT_W-1:0] step_adjust;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      crit_high: 12'sd900,
      crit_low: -12'sd200,
      rec_high: 12'sd700,
      rec_low: 12'sd100,
      ideal: 12'sd400,
      tolerance: 11'd20,
      full_adjust: 8'd255,
      step_adjust: 8'd16
   };

endpackage

// ===== design/tbcm_cell.sv =====
// One reading cell of the history chain: holds a sample and takes its
// neighbour's value on each advance. Depends on tbcm_pkg.
module tbcm_cell (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic signed [tbcm_pkg::SAMPLE_W-1:0] data_in,
   output logic signed [tbcm_pkg::SAMPLE_W-1:0] data_out
);
   import tbcm_pkg::*;

   logic signed [SAMPLE_W-1:0] reading_ff;
   logic signed [SAMPLE_W-1:0] reading_in;

   assign reading_in = advance ? data_in : reading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff <= '0;
      end else begin
         reading_ff <= reading_in;
      end
   end

   assign data_out = reading_ff;

endmodule

// ===== design/tbcm_classifier.sv =====
// Band classification of one sample plus average drift check against
// sum bounds derived from the registers. Depends on tbcm_pkg.
module tbcm_classifier #(
   parameter int RING_DEPTH = tbcm_pkg::DEFAULT_RING_DEPTH
) (
   input  tbcm_pkg::cfg_type cfg,
   input  logic signed [tbcm_pkg::SAMPLE_W-1:0] sample,
   input  logic signed [tbcm_pkg::SAMPLE_W+$clog2(RING_DEPTH)-1:0] sum,
   output tbcm_pkg::act_type action,
   output logic [tbcm_pkg::AMT_W-1:0] amount
);
   import tbcm_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);
   localparam int BND_W = SUM_W + 3;
   localparam logic signed [BND_W-1:0] DEPTH_S = BND_W'(RING_DEPTH);

   // Average limits ideal +/- tolerance, widened to hold the full range
   logic signed [LVL_W-1:0] lim_hi;
   logic signed [LVL_W-1:0] lim_lo;
   logic hi_nonneg;
   logic lo_pos;
   logic signed [LVL_W-1:0] hi_mult;
   logic signed [LVL_W-1:0] lo_mult;
   logic signed [BND_W-1:0] prod_hi;
   logic signed [BND_W-1:0] prod_lo;
   logic signed [BND_W-1:0] hi_bound;
   logic signed [BND_W-1:0] lo_bound;
   logic signed [BND_W-1:0] sum_wide;

   assign lim_hi = LVL_W'(cfg.ideal) + $signed({3'b000, cfg.tolerance});
   assign lim_lo = LVL_W'(cfg.ideal) - $signed({3'b000, cfg.tolerance});
   assign hi_nonneg = !lim_hi[LVL_W-1];
   assign lo_pos = !lim_lo[LVL_W-1] && (lim_lo != '0);

   // Truncated average above lim_hi  <=> sum >= hi bound,
   // truncated average below lim_lo  <=> sum <= lo bound.
   assign hi_mult = hi_nonneg ? lim_hi + LVL_W'(1) : lim_hi;
   assign lo_mult = lo_pos ? lim_lo : lim_lo - LVL_W'(1);
   assign prod_hi = DEPTH_S * BND_W'(hi_mult);
   assign prod_lo = DEPTH_S * BND_W'(lo_mult);
   assign hi_bound = hi_nonneg ? prod_hi : prod_hi + BND_W'(1);
   assign lo_bound = lo_pos ? prod_lo - BND_W'(1) : prod_lo;

   assign sum_wide = $signed({{(BND_W-SUM_W){sum[SUM_W-1]}}, sum});

   always_comb begin
      action = ACT_NONE;
      amount = '0;
      if (sample >= cfg.crit_high || sample <= cfg.crit_low) begin
         action = ACT_SHUTDOWN;
      end else if (sample >= cfg.rec_high) begin
         action = ACT_INCREASE;
         amount = cfg.full_adjust;
      end else if (sample <= cfg.rec_low) begin
         action = ACT_DECREASE;
         amount = cfg.full_adjust;
      end else if (sum_wide >= hi_bound) begin
         action = ACT_INCREASE;
         amount = cfg.step_adjust;
      end else if (sum_wide <= lo_bound) begin
         action = ACT_DECREASE;
         amount = cfg.step_adjust;
      end
   end

endmodule

// ===== design/temperature_band_cooling_monitor_top.sv =====
// Temperature band cooling monitor: classifies each sample against shutdown and
// recommended bands, or the running average against ideal +/- tolerance.
// A request passes through stage one and the output register to the response;
// throughput one transaction per cycle while the response stream is not stalled.
// Synchronous active-high reset clears the history chain and sum to zero,
// loads the register reset values and empties the pipeline.
module temperature_band_cooling_monitor_top #(
   parameter int RING_DEPTH = tbcm_pkg::DEFAULT_RING_DEPTH
) (
   input  logic clock,
   input  logic reset,
   // Request stream
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   // Response stream
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [7:0] rsp_tdata,    // [7:0] amount
   output logic [7:0] rsp_tuser,    // [1:0] action, [7:2] zero
   // Register write port
   input  logic csr_we,
   input  logic [tbcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbcm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tbcm_pkg::*;

   localparam int SUM_W = SAMPLE_W + $clog2(RING_DEPTH);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_CRIT_HIGH: cfg_in.crit_high = $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_CRIT_LOW:  cfg_in.crit_low = $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_REC_HIGH:  cfg_in.rec_high = $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_REC_LOW:   cfg_in.rec_low = $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_IDEAL:     cfg_in.ideal = $signed(csr_wdata[SAMPLE_W-1:0]);
            REG_TOLERANCE: cfg_in.tolerance = csr_wdata[TOL_W-1:0];
            REG_FULL_ADJ:  cfg_in.full_adjust = csr_wdata[AMT_W-1:0];
            REG_STEP_ADJ:  cfg_in.step_adjust = csr_wdata[AMT_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_valid_in;
   logic out_valid_ff;
   logic out_valid_in;
   logic out_load;
   logic s1_move;
   logic accept;

   // Output register frees up when empty or being taken; stage one drains
   // into it, so a new request is taken whenever stage one is empty or will move on.
   assign out_load = !out_valid_ff || rsp_tready;
   assign s1_move = s1_valid_ff && out_load;
   assign req_tready = !s1_valid_ff || out_load;
   assign accept = req_tvalid && req_tready;

   assign s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign out_valid_in = out_load ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Reading history: a chain of cells, newest at cell 0. The oldest
   // reading leaves from the far end as the new sample enters.
   // ---------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] chain [RING_DEPTH+1];

   assign sample = $signed(req_tdata[SAMPLE_W-1:0]);
   assign chain[0] = sample;

   for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
      tbcm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (accept),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   // Running sum: add the new sample, drop the oldest reading
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum_next;

   assign sum_next = sum_ff + SUM_W'(sample) - SUM_W'(chain[RING_DEPTH]);
   assign sum_in = accept ? sum_next : sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage one: hold the sample and the sum that includes it
   // ---------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] s1_sample_ff;
   logic signed [SUM_W-1:0] s1_sum_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_sum_ff <= sum_next;
      end
   end

   // ---------------------------------------------------------------
   // Classification and output register
   // ---------------------------------------------------------------
   act_type cls_action;
   logic [AMT_W-1:0] cls_amount;
   act_type out_action_ff;
   logic [AMT_W-1:0] out_amount_ff;

   tbcm_classifier #(
      .RING_DEPTH (RING_DEPTH)
   ) u_classifier (
      .cfg    (cfg_ff),
      .sample (s1_sample_ff),
      .sum    (s1_sum_ff),
      .action (cls_action),
      .amount (cls_amount)
   );

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_action_ff <= cls_action;
         out_amount_ff <= cls_amount;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_amount_ff;
   assign rsp_tuser = {6'b000000, out_action_ff};

endmodule

// ===== dv/temperature_band_cooling_monitor_checker.sv =====
// Checker for the temperature band cooling monitor: watches the register port and
// both streams, predicts each response and compares it. Depends on tbcm_pkg.
module temperature_band_cooling_monitor_checker #(
   parameter int RING_DEPTH = tbcm_pkg::DEFAULT_RING_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [15:0] req_tdata,   // [11:0] sample, [15:12] zero
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [7:0] rsp_tdata,    // [7:0] amount
   input  logic [7:0] rsp_tuser,    // [1:0] action, [7:2] zero
   input  logic csr_we,
   input  logic [tbcm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbcm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tbcm_pkg::*;

   typedef struct packed {
      act_type action;
      logic [AMT_W-1:0] amount;
   } cooling_order_type;

   cfg_type cfg;
   logic signed [SAMPLE_W-1:0] history [RING_DEPTH];
   int unsigned next_slot;
   int history_sum;
   cooling_order_type awaited_orders[$];

   // Classify the newest sample; the running total already includes it.
   function automatic cooling_order_type classify_reading(logic signed [SAMPLE_W-1:0] s,
                                                           int total);
      cooling_order_type r;
      int s_i;
      int mean;
      int crit_hi;
      int crit_lo;
      int rec_hi;
      int rec_lo;
      int ideal_i;
      int tol_i;
      s_i = int'(s);
      crit_hi = int'(cfg.crit_high);
      crit_lo = int'(cfg.crit_low);
      rec_hi = int'(cfg.rec_high);
      rec_lo = int'(cfg.rec_low);
      ideal_i = int'(cfg.ideal);
      tol_i = int'(cfg.tolerance);
      mean = total / RING_DEPTH;
      r.action = ACT_NONE;
      r.amount = '0;
      if (s_i >= crit_hi || s_i <= crit_lo) begin
         r.action = ACT_SHUTDOWN;
      end else if (s_i >= rec_hi) begin
         r.action = ACT_INCREASE;
         r.amount = cfg.full_adjust;
      end else if (s_i <= rec_lo) begin
         r.action = ACT_DECREASE;
         r.amount = cfg.full_adjust;
      end else if (mean > ideal_i + tol_i) begin
         r.action = ACT_INCREASE;
         r.amount = cfg.step_adjust;
      end else if (mean < ideal_i - tol_i) begin
         r.action = ACT_DECREASE;
         r.amount = cfg.step_adjust;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cooling_order_type got;
      cooling_order_type want;
      logic signed [SAMPLE_W-1:0] s;
      bit bad;
      if (reset) begin
         cfg = CFG_RESET;
         for (int i = 0; i < RING_DEPTH; i++) history[i] = '0;
         next_slot = 0;
         history_sum = 0;
         awaited_orders.delete();
         pending <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CRIT_HIGH: cfg.crit_high = csr_wdata[SAMPLE_W-1:0];
               REG_CRIT_LOW: cfg.crit_low = csr_wdata[SAMPLE_W-1:0];
               REG_REC_HIGH: cfg.rec_high = csr_wdata[SAMPLE_W-1:0];
               REG_REC_LOW: cfg.rec_low = csr_wdata[SAMPLE_W-1:0];
               REG_IDEAL: cfg.ideal = csr_wdata[SAMPLE_W-1:0];
               REG_TOLERANCE: cfg.tolerance = csr_wdata[TOL_W-1:0];
               REG_FULL_ADJ: cfg.full_adjust = csr_wdata[AMT_W-1:0];
               REG_STEP_ADJ: cfg.step_adjust = csr_wdata[AMT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.action = act_type'(rsp_tuser[ACT_W-1:0]);
            got.amount = rsp_tdata[AMT_W-1:0];
            if (awaited_orders.size() == 0) begin
               $error("unexpected response: action %0d amount %0d", got.action, got.amount);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_orders.pop_front();
               bad = 0;
               if (got.action != want.action) begin
                  $error("action: expected %0d, actual %0d", want.action, got.action);
                  bad = 1;
               end
               if (got.amount != want.amount) begin
                  $error("amount: expected %0d, actual %0d", want.amount, got.amount);
                  bad = 1;
               end
               if (bad) fail_count <= fail_count + 1;
            end
         end
         if (req_tvalid && req_tready) begin
            s = req_tdata[SAMPLE_W-1:0];
            history_sum = history_sum + int'(s) - int'(history[next_slot]);
            history[next_slot] = s;
            next_slot = (next_slot + 1) % RING_DEPTH;
            awaited_orders.push_back(classify_reading(s, history_sum));
         end
         pending <= awaited_orders.size();
      end
   end

endmodule

// ===== dv/temperature_band_cooling_monitor_top_tb.sv =====
// Testbench top for the temperature band cooling monitor: clock, reset, stimulus
// and verdict. Depends on tbcm_pkg, the block and temperature_band_cooling_monitor_checker.
module temperature_band_cooling_monitor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tbcm_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int DRAIN_CYCLES = 8;       // idle margin after the last response
   localparam int HOLD_CYCLES = 150;      // long receiver back-pressure stretch
   localparam int CYCLE_LIMIT = 400000;

   // Every block input starts at a known value.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [7:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int chk_fails;
   int chk_pending;
   int cycle_count = 0;

   // Flags shared between the stimulus and the receiver process.
   bit tx_no_gap = 0;
   bit rx_no_gap = 0;
   bit hold_request = 0;

   // Sender-side copy of the settings, used only to aim samples at the bands.
   cfg_type cur_cfg = CFG_RESET;

   temperature_band_cooling_monitor_top u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   temperature_band_cooling_monitor_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(chk_fails),
      .pending(chk_pending)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Guard against a hung handshake: stop the run once the cycle budget is spent.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[temperature_band_cooling_monitor_top] ERROR");
         $finish;
      end
   end

   // Receiver: accept most cycles, idle at random, or hold off for a long
   // stretch on request so that the block fills and stalls its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= rx_no_gap || ($urandom_range(99) >= 15);
         end
      end
   end

   function automatic logic [SAMPLE_W-1:0] clamp12(int v);
      int c;
      c = v;
      if (c > 2047) c = 2047;
      if (c < -2048) c = -2048;
      return c[SAMPLE_W-1:0];
   endfunction

   // Offer one sample, with random idle cycles first, and hold it until accepted.
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while (!tx_no_gap && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, s};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid, wait for every outstanding response, then let the pipe drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chk_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Write every register; pad the narrow ones with junk to show it is dropped.
   task automatic load_config(input cfg_type c);
      logic [31:0] junk;
      junk = $urandom;
      write_reg(REG_CRIT_HIGH, c.crit_high);
      write_reg(REG_CRIT_LOW, c.crit_low);
      write_reg(REG_REC_HIGH, c.rec_high);
      write_reg(REG_REC_LOW, c.rec_low);
      write_reg(REG_IDEAL, c.ideal);
      write_reg(REG_TOLERANCE, {junk[0], c.tolerance});
      write_reg(REG_FULL_ADJ, {junk[4:1], c.full_adjust});
      write_reg(REG_STEP_ADJ, {junk[8:5], c.step_adjust});
      cur_cfg = c;
   endtask

   // Settings: 0 ordered bands, 1 wide open bands, 2 anything (crossed bands).
   function automatic cfg_type rand_config(int mode);
      cfg_type c;
      int ideal_i;
      int tol_i;
      int rec_lo;
      int rec_hi;
      c.full_adjust = 8'($urandom_range(255));
      c.step_adjust = 8'($urandom_range(255));
      if (mode == 0) begin
         ideal_i = $urandom_range(3000) - 1500;
         tol_i = $urandom_range(200);
         rec_lo = ideal_i - tol_i - int'($urandom_range(300));
         rec_hi = ideal_i + tol_i + int'($urandom_range(300));
         c.ideal = clamp12(ideal_i);
         c.tolerance = 11'(tol_i);
         c.rec_low = clamp12(rec_lo);
         c.rec_high = clamp12(rec_hi);
         c.crit_low = clamp12(rec_lo - int'($urandom_range(300)));
         c.crit_high = clamp12(rec_hi + int'($urandom_range(300)));
      end else if (mode == 1) begin
         c.crit_high = 12'sd2047;
         c.crit_low = -12'sd2048;
         c.rec_high = 12'sd2047;
         c.rec_low = -12'sd2048;
         c.ideal = 12'($urandom);
         c.tolerance = $urandom_range(1) ? 11'd2047
                                         : 11'(($urandom_range(1) ? 0 : $urandom_range(64)));
      end else begin
         c.crit_high = 12'($urandom);
         c.crit_low = 12'($urandom);
         c.rec_high = 12'($urandom);
         c.rec_low = 12'($urandom);
         c.ideal = 12'($urandom);
         c.tolerance = 11'($urandom);
      end
      return c;
   endfunction

   // Mostly aim near a band edge or around the ideal level so runs of samples
   // steer the average; the rest is full-range noise.
   function automatic logic [SAMPLE_W-1:0] pick_sample(cfg_type c);
      int r;
      int base;
      int span;
      int d;
      r = $urandom_range(99);
      if (r < 30) return 12'($urandom);
      if (r < 55) begin
         case ($urandom_range(5))
            0: base = int'(c.crit_high);
            1: base = int'(c.crit_low);
            2: base = int'(c.rec_high);
            3: base = int'(c.rec_low);
            4: base = int'(c.ideal) + int'(c.tolerance);
            default: base = int'(c.ideal) - int'(c.tolerance);
         endcase
         d = $urandom_range(4);
         return clamp12(base + d - 2);
      end
      span = int'(c.tolerance) + 40;
      if (span > 400) span = 400;
      d = $urandom_range(2 * span);
      return clamp12(int'(c.ideal) + d - span);
   endfunction

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++) send_sample(pick_sample(cur_cfg));
   endtask

   initial begin
      cfg_type c;
      // Hold reset, then release it once.
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings: both sample extremes, each band edge on both
      // sides, and a few in-band samples that go through the average.
      send_sample(12'sd2047);
      send_sample(-12'sd2048);
      send_sample(12'sd900);
      send_sample(12'sd899);
      send_sample(-12'sd200);
      send_sample(-12'sd199);
      send_sample(12'sd700);
      send_sample(12'sd100);
      send_sample(12'sd101);
      send_sample(12'sd699);
      repeat (3) send_sample(12'sd400);

      // Directed, wide bands around zero: a small negative ring total must
      // truncate toward zero and give no action; a total of -8 then decreases.
      settle();
      c = '{crit_high: 12'sd2047, crit_low: -12'sd2048, rec_high: 12'sd2047,
            rec_low: -12'sd2048, ideal: 12'sd0, tolerance: 11'd0,
            full_adjust: 8'd0, step_adjust: 8'd255};
      load_config(c);
      repeat (7) send_sample(12'sd0);
      send_sample(-12'sd5);
      send_sample(-12'sd3);

      // Directed, crossed recommended bands: the increase rule wins.
      settle();
      c.rec_high = 12'sd0;
      c.rec_low = 12'sd50;
      load_config(c);
      send_sample(12'sd10);
      send_sample(12'sd0);
      send_sample(12'sd50);

      // Random, reset settings, sender never idles.
      settle();
      load_config(CFG_RESET);
      tx_no_gap = 1;
      run_random(250);
      tx_no_gap = 0;

      // Random, wide bands with zero tolerance; neither side idles.
      settle();
      c = rand_config(1);
      c.ideal = 12'sd0;
      c.tolerance = 11'd0;
      c.full_adjust = 8'd255;
      c.step_adjust = 8'd1;
      load_config(c);
      tx_no_gap = 1;
      rx_no_gap = 1;
      run_random(250);
      tx_no_gap = 0;
      rx_no_gap = 0;

      // Random, ordered bands, with a long receiver hold-off at the start
      // while the sender keeps offering.
      settle();
      load_config(rand_config(0));
      hold_request = 1;
      run_random(300);

      // Random, unordered registers: crossed bands of every kind.
      settle();
      load_config(rand_config(2));
      run_random(250);

      // Random, register extremes: everything shuts down.
      settle();
      c = '{crit_high: -12'sd2048, crit_low: 12'sd2047, rec_high: -12'sd2048,
            rec_low: 12'sd2047, ideal: 12'sd2047, tolerance: 11'd2047,
            full_adjust: 8'd255, step_adjust: 8'd255};
      load_config(c);
      run_random(100);

      // Random, wide bands, lowest ideal and widest tolerance.
      settle();
      c = rand_config(1);
      c.ideal = -12'sd2048;
      c.tolerance = 11'd2047;
      c.full_adjust = 8'd0;
      c.step_adjust = 8'd0;
      load_config(c);
      run_random(150);

      // Random, a mix of fresh settings.
      for (int p = 0; p < 6; p++) begin
         settle();
         load_config(rand_config(p % 3));
         run_random(100);
      end

      // Wait for every response, then give the verdict.
      settle();
      if (chk_fails == 0) begin
         $display("[temperature_band_cooling_monitor_top] OK");
      end else begin
         $display("[temperature_band_cooling_monitor_top] ERROR");
      end
      $finish;
   end

endmodule
